// ===== hdl/csc_pkg.sv =====
// Shared types and constants for the two-sprite color-key compositor.
// Holds command and layer codes, field widths and the layer geometry struct.
// No dependencies.
package csc_pkg;

    localparam int POS_W   = 10;
    localparam int SIZE_W  = 7;
    localparam int PIX_W   = 16;
    localparam int CMD_W   = 2;
    localparam int LAYER_W = 2;
    localparam int IDX_W   = 15;
    localparam int REG_W   = 3;

    localparam logic [CMD_W-1:0] CMD_LOAD_FRONT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_MIDDLE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPOSITE   = 2'd2;

    localparam logic [LAYER_W-1:0] LAYER_BG     = 2'd0;
    localparam logic [LAYER_W-1:0] LAYER_MIDDLE = 2'd1;
    localparam logic [LAYER_W-1:0] LAYER_FRONT  = 2'd2;

    localparam logic [REG_W-1:0] REG_FRONT_X  = 3'd0;
    localparam logic [REG_W-1:0] REG_FRONT_Y  = 3'd1;
    localparam logic [REG_W-1:0] REG_FRONT_W  = 3'd2;
    localparam logic [REG_W-1:0] REG_FRONT_H  = 3'd3;
    localparam logic [REG_W-1:0] REG_MIDDLE_X = 3'd4;
    localparam logic [REG_W-1:0] REG_MIDDLE_Y = 3'd5;
    localparam logic [REG_W-1:0] REG_MIDDLE_W = 3'd6;
    localparam logic [REG_W-1:0] REG_MIDDLE_H = 3'd7;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    typedef struct packed {
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
    } t_layer_cfg;

endpackage

// ===== hdl/csc_sprite_ram.sv =====
// Single-port sprite pixel memory with a registered read.
// Uses csc_pkg for the pixel width.
module csc_sprite_ram
    import csc_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [AW-1:0]    i_addr,
    input  logic [PIX_W-1:0] i_wdata,
    output logic [PIX_W-1:0] o_rdata
);

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/csc_layer_addr.sv =====
// Sprite address generator: maps a coordinate to a sprite memory index and
// flags whether it lies inside the sprite. Uses csc_pkg.
module csc_layer_addr
    import csc_pkg::*;
#(
    parameter int SPRITE_MAX_PIXELS = 4096,
    parameter int AW                = 12
) (
    input  t_layer_cfg       i_cfg,
    input  logic             i_load,
    input  logic [POS_W-1:0] i_pos_x,
    input  logic [POS_W-1:0] i_pos_y,
    output logic             o_hit,
    output logic [AW-1:0]    o_addr
);

    localparam int XW = (AW > IDX_W) ? AW : IDX_W;

    logic [POS_W-1:0] base_x;
    logic [POS_W-1:0] base_y;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [IDX_W-1:0] idx;
    logic [XW-1:0]    idx_x;
    logic             in_box;

    // Loads use image coordinates, composites are offset by the sprite corner.
    assign base_x = i_load ? '0 : i_cfg.x;
    assign base_y = i_load ? '0 : i_cfg.y;
    assign col    = i_pos_x - base_x;
    assign row    = i_pos_y - base_y;

    assign in_box = (i_pos_x >= base_x) && (i_pos_y >= base_y)
                  && (col < POS_W'(i_cfg.w)) && (row < POS_W'(i_cfg.h));

    assign idx    = IDX_W'(row[SIZE_W-1:0]) * IDX_W'(i_cfg.w) + IDX_W'(col[SIZE_W-1:0]);
    assign idx_x  = XW'(idx);
    assign o_addr = idx_x[AW-1:0];
    assign o_hit  = in_box && (32'(idx) < 32'(SPRITE_MAX_PIXELS));

endmodule

// ===== hdl/csc_regs.sv =====
// Configuration register file behind an APB-style port.
// Holds the position and size of both sprites. Uses csc_pkg.
module csc_regs
    import csc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready,
    output t_layer_cfg  o_front,
    output t_layer_cfg  o_middle
);

    t_layer_cfg       r_front;
    t_layer_cfg       r_middle;
    logic             wr_en;
    logic [REG_W-1:0] reg_sel;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite;
    assign reg_sel  = i_paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '{x: '0, y: '0, w: SIZE_RESET, h: SIZE_RESET};
            r_middle <= '{x: '0, y: '0, w: SIZE_RESET, h: SIZE_RESET};
        end else if (wr_en) begin
            case (reg_sel)
                REG_FRONT_X:  r_front.x  <= i_pwdata[POS_W-1:0];
                REG_FRONT_Y:  r_front.y  <= i_pwdata[POS_W-1:0];
                REG_FRONT_W:  r_front.w  <= i_pwdata[SIZE_W-1:0];
                REG_FRONT_H:  r_front.h  <= i_pwdata[SIZE_W-1:0];
                REG_MIDDLE_X: r_middle.x <= i_pwdata[POS_W-1:0];
                REG_MIDDLE_Y: r_middle.y <= i_pwdata[POS_W-1:0];
                REG_MIDDLE_W: r_middle.w <= i_pwdata[SIZE_W-1:0];
                REG_MIDDLE_H: r_middle.h <= i_pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_FRONT_X:  o_prdata = 32'(r_front.x);
            REG_FRONT_Y:  o_prdata = 32'(r_front.y);
            REG_FRONT_W:  o_prdata = 32'(r_front.w);
            REG_FRONT_H:  o_prdata = 32'(r_front.h);
            REG_MIDDLE_X: o_prdata = 32'(r_middle.x);
            REG_MIDDLE_Y: o_prdata = 32'(r_middle.y);
            REG_MIDDLE_W: o_prdata = 32'(r_middle.w);
            REG_MIDDLE_H: o_prdata = 32'(r_middle.h);
            default:      o_prdata = '0;
        endcase
    end

    assign o_front  = r_front;
    assign o_middle = r_middle;

endmodule

// ===== hdl/two_sprite_color_key_compositor_top.sv =====
// Two-sprite color-key compositor, top level. Uses csc_pkg, csc_regs,
// csc_layer_addr and csc_sprite_ram.
// A composite item passes through the sprite memory reads and stage-one registers, then the output register.
// Throughput: one item per cycle unless the output is stalled, set by one read or write of each sprite memory.
// Loads write the memory at acceptance and give no result.
// Reset clears the registers and pipeline; sprite memories stay undefined.
module two_sprite_color_key_compositor_top
    import csc_pkg::*;
#(
    parameter int SPRITE_MAX_PIXELS = 4096,
    parameter int TRANSPARENT_KEY   = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // pos_x[9:0], pos_y[19:10], pixel_in[35:20], zero pad
    input  logic [1:0]  i_s_tuser,   // command[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // pixel_out[15:0]
    output logic [1:0]  o_m_tuser,   // source_layer[1:0]
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam int AW = (SPRITE_MAX_PIXELS > 1) ? $clog2(SPRITE_MAX_PIXELS) : 1;
    localparam logic [PIX_W-1:0] KEY = PIX_W'(TRANSPARENT_KEY);

    t_layer_cfg       front_cfg;
    t_layer_cfg       middle_cfg;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [PIX_W-1:0] pixel_in;
    logic             in_accept;
    logic             is_comp;
    logic             s1_adv;
    logic             front_hit;
    logic             middle_hit;
    logic [AW-1:0]    front_addr;
    logic [AW-1:0]    middle_addr;
    logic [PIX_W-1:0] front_rdata;
    logic [PIX_W-1:0] middle_rdata;
    logic             front_opaque;
    logic             middle_opaque;
    logic [PIX_W-1:0] n_out_pixel;
    logic [LAYER_W-1:0] n_out_layer;

    logic               r_s1_valid;
    logic [PIX_W-1:0]   r_s1_bg;
    logic               r_s1_front_hit;
    logic               r_s1_middle_hit;
    logic               r_out_valid;
    logic [PIX_W-1:0]   r_out_pixel;
    logic [LAYER_W-1:0] r_out_layer;

    assign cmd      = i_s_tuser;
    assign pos_x    = i_s_tdata[9:0];
    assign pos_y    = i_s_tdata[19:10];
    assign pixel_in = i_s_tdata[35:20];

    assign s1_adv     = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || s1_adv;
    assign in_accept  = i_s_tvalid && o_s_tready;
    assign is_comp    = (cmd == CMD_COMPOSITE);

    csc_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_front   (front_cfg),
        .o_middle  (middle_cfg)
    );

    csc_layer_addr #(.SPRITE_MAX_PIXELS(SPRITE_MAX_PIXELS), .AW(AW)) u_front_addr (
        .i_cfg   (front_cfg),
        .i_load  (!is_comp),
        .i_pos_x (pos_x),
        .i_pos_y (pos_y),
        .o_hit   (front_hit),
        .o_addr  (front_addr)
    );

    csc_layer_addr #(.SPRITE_MAX_PIXELS(SPRITE_MAX_PIXELS), .AW(AW)) u_middle_addr (
        .i_cfg   (middle_cfg),
        .i_load  (!is_comp),
        .i_pos_x (pos_x),
        .i_pos_y (pos_y),
        .o_hit   (middle_hit),
        .o_addr  (middle_addr)
    );

    csc_sprite_ram #(.DEPTH(SPRITE_MAX_PIXELS), .AW(AW)) u_front_ram (
        .i_clk   (i_clk),
        .i_we    (in_accept && (cmd == CMD_LOAD_FRONT) && front_hit),
        .i_re    (in_accept && is_comp),
        .i_addr  (front_addr),
        .i_wdata (pixel_in),
        .o_rdata (front_rdata)
    );

    csc_sprite_ram #(.DEPTH(SPRITE_MAX_PIXELS), .AW(AW)) u_middle_ram (
        .i_clk   (i_clk),
        .i_we    (in_accept && (cmd == CMD_LOAD_MIDDLE) && middle_hit),
        .i_re    (in_accept && is_comp),
        .i_addr  (middle_addr),
        .i_wdata (pixel_in),
        .o_rdata (middle_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= in_accept && is_comp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && is_comp) begin
            r_s1_bg         <= pixel_in;
            r_s1_front_hit  <= front_hit;
            r_s1_middle_hit <= middle_hit;
        end
    end

    assign front_opaque  = r_s1_front_hit && (front_rdata != KEY);
    assign middle_opaque = r_s1_middle_hit && (middle_rdata != KEY);

    always_comb begin
        n_out_pixel = r_s1_bg;
        n_out_layer = LAYER_BG;
        if (front_opaque) begin
            n_out_pixel = front_rdata;
            n_out_layer = LAYER_FRONT;
        end else if (middle_opaque) begin
            n_out_pixel = middle_rdata;
            n_out_layer = LAYER_MIDDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_pixel <= n_out_pixel;
            r_out_layer <= n_out_layer;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_pixel;
    assign o_m_tuser  = r_out_layer;

    a_layer_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_layer == LAYER_BG || r_out_layer == LAYER_MIDDLE
                         || r_out_layer == LAYER_FRONT))
        else $error("result carries an unused layer code");

    a_s1_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !$past(r_s1_valid)) |-> $past(in_accept && is_comp))
        else $error("stage one filled without an accepted composite item");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_bg)
                                     && $stable(front_rdata) && $stable(middle_rdata)))
        else $error("stalled composite lost its data");

    a_front_wins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_adv && front_opaque) |=> (r_out_layer == LAYER_FRONT))
        else $error("opaque front sprite pixel did not win");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for two_sprite_color_key_compositor_top.
// Depends on csc_pkg and the compositor RTL. A scoreboard predicts every composite
// pixel and its layer across many sprite placements, including empty and oversized ones.
module tb_top;
    import csc_pkg::*;

    localparam int STORE_DEPTH = 4096;
    localparam int KEY_VALUE = 0;
    localparam logic [PIX_W-1:0] KEY_COLOR = PIX_W'(KEY_VALUE);
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int MAX_WAIT = 12;
    localparam int DRAIN_CYCLES = 6;
    localparam int POS_MAX = 1023;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [PIX_W-1:0] pix;
    } t_pixel_cmd;

    typedef struct packed {
        logic [PIX_W-1:0]   pix;
        logic [LAYER_W-1:0] layer;
    } t_composite;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [39:0] in_data = '0;
    logic [1:0]  in_cmd = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] out_pix;
    logic [1:0]  out_layer;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    t_layer_cfg       front_geom;
    t_layer_cfg       middle_geom;
    logic [PIX_W-1:0] front_pixels [STORE_DEPTH];
    logic [PIX_W-1:0] middle_pixels [STORE_DEPTH];
    bit               front_loaded [STORE_DEPTH];
    bit               middle_loaded [STORE_DEPTH];
    t_pixel_cmd       command_queue [$];
    t_composite       expected_pixels [$];

    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int layer_hits [3] = '{0, 0, 0};
    int settings_used = 0;
    int send_wait = 0;
    int recv_wait = 0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;

    two_sprite_color_key_compositor_top #(
        .SPRITE_MAX_PIXELS(STORE_DEPTH),
        .TRANSPARENT_KEY(KEY_VALUE)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_s_tvalid(in_valid),
        .o_s_tready(in_ready),
        .i_s_tdata(in_data),
        .i_s_tuser(in_cmd),
        .o_m_tvalid(out_valid),
        .i_m_tready(out_ready),
        .o_m_tdata(out_pix),
        .o_m_tuser(out_layer),
        .i_psel(psel),
        .i_penable(penable),
        .i_pwrite(pwrite),
        .i_paddr(paddr),
        .i_pwdata(pwdata),
        .o_prdata(prdata),
        .o_pready(pready)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic int image_index(t_layer_cfg g, int col, int row);
        int idx;
        if (col >= int'(g.w) || row >= int'(g.h)) return -1;
        idx = row * int'(g.w) + col;
        return (idx >= STORE_DEPTH) ? -1 : idx;
    endfunction

    function automatic int display_index(t_layer_cfg g, int dx, int dy);
        if (dx < int'(g.x) || dy < int'(g.y)) return -1;
        return image_index(g, dx - int'(g.x), dy - int'(g.y));
    endfunction

    function automatic void apply_pixel_command(t_pixel_cmd c);
        int idx;
        t_composite r;
        case (c.cmd)
            CMD_LOAD_FRONT: begin
                idx = image_index(front_geom, int'(c.x), int'(c.y));
                if (idx >= 0) front_pixels[idx] = c.pix;
            end
            CMD_LOAD_MIDDLE: begin
                idx = image_index(middle_geom, int'(c.x), int'(c.y));
                if (idx >= 0) middle_pixels[idx] = c.pix;
            end
            CMD_COMPOSITE: begin
                r.pix = c.pix;
                r.layer = LAYER_BG;
                idx = display_index(middle_geom, int'(c.x), int'(c.y));
                if (idx >= 0 && middle_pixels[idx] != KEY_COLOR) begin
                    r.pix = middle_pixels[idx];
                    r.layer = LAYER_MIDDLE;
                end
                idx = display_index(front_geom, int'(c.x), int'(c.y));
                if (idx >= 0 && front_pixels[idx] != KEY_COLOR) begin
                    r.pix = front_pixels[idx];
                    r.layer = LAYER_FRONT;
                end
                expected_pixels.push_back(r);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        return ($urandom_range(0, 3) == 0) ? KEY_COLOR : PIX_W'($urandom);
    endfunction

    function automatic t_layer_cfg random_layer();
        t_layer_cfg g;
        g.x = POS_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 160) : $urandom_range(0, POS_MAX));
        g.y = POS_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 160) : $urandom_range(0, POS_MAX));
        g.w = SIZE_W'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 64) : $urandom_range(0, 127));
        g.h = SIZE_W'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 64) : $urandom_range(0, 127));
        return g;
    endfunction

    // Loads are tracked here as they are queued, so composites never touch an empty entry.
    task automatic queue_item(input logic [CMD_W-1:0] cmd, input int col, input int row,
                              input logic [PIX_W-1:0] pix);
        t_pixel_cmd c;
        int idx;
        c.cmd = cmd;
        c.x = POS_W'(col);
        c.y = POS_W'(row);
        c.pix = pix;
        command_queue.push_back(c);
        if (cmd == CMD_LOAD_FRONT) begin
            idx = image_index(front_geom, col, row);
            if (idx >= 0) front_loaded[idx] = 1'b1;
        end else if (cmd == CMD_LOAD_MIDDLE) begin
            idx = image_index(middle_geom, col, row);
            if (idx >= 0) middle_loaded[idx] = 1'b1;
        end
    endtask

    task automatic add_composite(input int x, input int y, input logic [PIX_W-1:0] bg);
        int idx;
        idx = display_index(middle_geom, x, y);
        if (idx >= 0 && !middle_loaded[idx])
            queue_item(CMD_LOAD_MIDDLE, x - int'(middle_geom.x), y - int'(middle_geom.y),
                       random_pixel());
        idx = display_index(front_geom, x, y);
        if (idx >= 0 && !front_loaded[idx])
            queue_item(CMD_LOAD_FRONT, x - int'(front_geom.x), y - int'(front_geom.y),
                       random_pixel());
        queue_item(CMD_COMPOSITE, x, y, bg);
    endtask

    task automatic write_reg(input logic [REG_W-1:0] r, input logic [POS_W-1:0] v);
        logic [31:0] word;
        word = ($urandom_range(0, 1) == 1) ? $urandom : 32'h0;
        if (r == REG_FRONT_W || r == REG_FRONT_H || r == REG_MIDDLE_W || r == REG_MIDDLE_H)
            word[SIZE_W-1:0] = v[SIZE_W-1:0];
        else
            word[POS_W-1:0] = v;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            REG_FRONT_X:  front_geom.x = word[POS_W-1:0];
            REG_FRONT_Y:  front_geom.y = word[POS_W-1:0];
            REG_FRONT_W:  front_geom.w = word[SIZE_W-1:0];
            REG_FRONT_H:  front_geom.h = word[SIZE_W-1:0];
            REG_MIDDLE_X: middle_geom.x = word[POS_W-1:0];
            REG_MIDDLE_Y: middle_geom.y = word[POS_W-1:0];
            REG_MIDDLE_W: middle_geom.w = word[SIZE_W-1:0];
            REG_MIDDLE_H: middle_geom.h = word[SIZE_W-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic set_layers(input t_layer_cfg f, input t_layer_cfg m);
        write_reg(REG_FRONT_X, f.x);
        write_reg(REG_FRONT_Y, f.y);
        write_reg(REG_FRONT_W, POS_W'(f.w));
        write_reg(REG_FRONT_H, POS_W'(f.h));
        write_reg(REG_MIDDLE_X, m.x);
        write_reg(REG_MIDDLE_Y, m.y);
        write_reg(REG_MIDDLE_W, POS_W'(m.w));
        write_reg(REG_MIDDLE_H, POS_W'(m.h));
        settings_used++;
    endtask

    task automatic wait_idle();
        do @(posedge clk);
        while (command_queue.size() != 0 || in_valid || expected_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        int sel;
        int col;
        int row;
        t_layer_cfg g;
        repeat (count) begin
            sel = $urandom_range(0, 19);
            g = ($urandom_range(0, 1) == 1) ? front_geom : middle_geom;
            if (sel < 12) begin
                g = (sel < 6) ? front_geom : middle_geom;
                col = ($urandom_range(0, 7) == 0) ? $urandom_range(0, POS_MAX)
                                                 : $urandom_range(0, int'(g.w) + 1);
                row = ($urandom_range(0, 7) == 0) ? $urandom_range(0, POS_MAX)
                                                 : $urandom_range(0, int'(g.h) + 1);
                queue_item((sel < 6) ? CMD_LOAD_FRONT : CMD_LOAD_MIDDLE, col, row,
                           random_pixel());
            end else if (sel < 19) begin
                if ($urandom_range(0, 4) == 0) begin
                    col = $urandom_range(0, POS_MAX);
                    row = $urandom_range(0, POS_MAX);
                end else begin
                    col = $urandom_range(0, int'(g.w) + 2);
                    row = $urandom_range(0, int'(g.h) + 2);
                    col = col + int'(g.x) - 1;
                    row = row + int'(g.y) - 1;
                    if (col < 0) col = 0;
                    if (row < 0) row = 0;
                    if (col > POS_MAX) col = POS_MAX;
                    if (row > POS_MAX) row = POS_MAX;
                end
                add_composite(col, row, PIX_W'($urandom));
            end else begin
                queue_item(CMD_UNUSED, $urandom_range(0, POS_MAX), $urandom_range(0, POS_MAX),
                           PIX_W'($urandom));
            end
        end
    endtask

    always @(posedge clk) begin : drive_inputs
        t_pixel_cmd c;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_wait <= 0;
        end else begin
            if (in_valid && in_ready) begin
                c.cmd = in_cmd;
                c.x = in_data[9:0];
                c.y = in_data[19:10];
                c.pix = in_data[35:20];
                apply_pixel_command(c);
                items_sent++;
            end
            if (!in_valid || in_ready) begin
                if (send_wait != 0) begin
                    send_wait <= send_wait - 1;
                    in_valid <= 1'b0;
                end else if (command_queue.size() != 0) begin
                    c = command_queue.pop_front();
                    in_data <= {4'b0000, c.pix, c.y, c.x};
                    in_cmd <= c.cmd;
                    in_valid <= 1'b1;
                    send_wait <= send_calm ? 0 : int'($urandom_range(0, MAX_WAIT));
                    if ($urandom_range(0, 39) == 0) send_calm <= !send_calm;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : check_outputs
        t_composite want;
        int next_wait;
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_wait <= 0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (expected_pixels.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got pixel %h layer %0d",
                             $time, out_pix, out_layer);
                end else begin
                    want = expected_pixels.pop_front();
                    layer_hits[want.layer]++;
                    if (out_pix !== want.pix) begin
                        errors++;
                        $display("%0t: pixel mismatch, expected %h, got %h",
                                 $time, want.pix, out_pix);
                    end
                    if (out_layer !== want.layer) begin
                        errors++;
                        $display("%0t: layer mismatch, expected %0d, got %0d",
                                 $time, want.layer, out_layer);
                    end
                end
                next_wait = recv_calm ? 0 : int'($urandom_range(0, MAX_WAIT));
                if ($urandom_range(0, 39) == 0) recv_calm <= !recv_calm;
            end else begin
                next_wait = (recv_wait > 0) ? recv_wait - 1 : 0;
            end
            recv_wait <= next_wait;
            out_ready <= (next_wait == 0);
        end
    end

    initial begin : stimulus
        t_layer_cfg f;
        t_layer_cfg m;
        front_geom = '{x: '0, y: '0, w: SIZE_RESET, h: SIZE_RESET};
        middle_geom = front_geom;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset placement: both sprites at the origin, 64 by 64.
        queue_item(CMD_LOAD_FRONT, 0, 0, 16'hFFFF);
        queue_item(CMD_LOAD_FRONT, 63, 63, 16'h0001);
        queue_item(CMD_LOAD_MIDDLE, 0, 0, 16'h8000);
        queue_item(CMD_LOAD_MIDDLE, 63, 63, KEY_COLOR);
        queue_item(CMD_LOAD_MIDDLE, 1, 0, 16'h7BEF);
        queue_item(CMD_LOAD_FRONT, 1, 0, KEY_COLOR);
        queue_item(CMD_LOAD_FRONT, 2, 0, KEY_COLOR);
        queue_item(CMD_LOAD_MIDDLE, 2, 0, KEY_COLOR);
        queue_item(CMD_LOAD_FRONT, 64, 0, 16'h1111);
        queue_item(CMD_LOAD_MIDDLE, 0, 64, 16'h2222);
        queue_item(CMD_LOAD_FRONT, POS_MAX, POS_MAX, 16'hFFFF);
        queue_item(CMD_UNUSED, POS_MAX, POS_MAX, 16'hFFFF);
        add_composite(0, 0, 16'hABCD);
        add_composite(63, 63, 16'h0000);
        add_composite(1, 0, 16'hFFFF);
        add_composite(2, 0, 16'h0F0F);
        add_composite(64, 64, KEY_COLOR);
        add_composite(64, 0, 16'h5555);
        add_composite(POS_MAX, POS_MAX, 16'hFFFF);
        wait_idle();

        // Front sprite hanging off the bottom right corner, middle sprite one pixel.
        f = '{x: 10'd1023, y: 10'd1023, w: 7'd64, h: 7'd64};
        m = '{x: 10'd0, y: 10'd0, w: 7'd1, h: 7'd1};
        set_layers(f, m);
        add_composite(POS_MAX, POS_MAX, 16'h1234);
        add_composite(POS_MAX - 1, POS_MAX, 16'h4321);
        add_composite(0, 0, 16'h0000);
        random_phase(150);
        wait_idle();

        // Empty sprites.
        f = '{x: 10'd0, y: 10'd0, w: 7'd0, h: 7'd5};
        m = '{x: 10'd0, y: 10'd0, w: 7'd10, h: 7'd0};
        set_layers(f, m);
        add_composite(0, 0, 16'h00FF);
        random_phase(80);
        wait_idle();

        // Sizes beyond what the sprite memory holds.
        f = '{x: 10'd0, y: 10'd0, w: 7'd127, h: 7'd127};
        m = '{x: 10'd5, y: 10'd5, w: 7'd100, h: 7'd50};
        set_layers(f, m);
        add_composite(126, 126, 16'hCAFE);
        add_composite(0, 40, 16'hBEEF);
        random_phase(200);
        wait_idle();

        repeat (5) begin
            set_layers(random_layer(), random_layer());
            random_phase(180);
            wait_idle();
        end

        $display("Covered %0d items over %0d sprite placements; %0d composites checked",
                 items_sent, settings_used, results_seen);
        $display("Winning layers: %0d background, %0d middle, %0d front",
                 layer_hits[0], layer_hits[1], layer_hits[2]);
        if (errors == 0) begin
            $display("two_sprite_color_key_compositor_top test passed");
        end else begin
            $display("two_sprite_color_key_compositor_top test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #20000000;
        $display("two_sprite_color_key_compositor_top test failed");
        $finish;
    end

endmodule
